>>> src/smbs_pkg.sv
// Shared types and constants for the sorted matrix search unit.
`timescale 1ns / 1ps

package smbs_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_PROBE,
        ST_ROW_FIRST,
        ST_ROW_LAST,
        ST_COL_PROBE,
        ST_COL_CMP
    } state_t;

endpackage

>>> src/sorted_matrix_binary_search_unit.sv
// Load: no result. Query: result strobe (done) in the cycle after the last compare.
// A query reads matrix words one at a time through the single read port of the store.
// Row probes pass ST_ROW_PROBE, ST_ROW_FIRST and, if needed, ST_ROW_LAST; column probes
// pass ST_COL_PROBE and ST_COL_CMP. A zero count skips the search. One item at a time (busy).
// Reset (rst_n, async, low) clears control and sets both counts to 16; store is not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`timescale 1ns / 1ps

module sorted_matrix_binary_search_unit
    import smbs_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] target,
    output logic                     done,
    output logic                     found,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CNT_W-1:0]         cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam int IW     = (RCW > CCW) ? RCW : CCW;

    logic signed [DATA_W-1:0] matrix_store [DEPTH];

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         row_count_reg, col_count_reg;
    logic [IW-1:0]            lo_reg, lo_next;
    logic [IW-1:0]            hi_reg, hi_next;
    logic [IW-1:0]            mid_reg, mid_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic signed [DATA_W-1:0] target_reg, target_next;
    logic signed [DATA_W-1:0] rdata_reg;
    logic                     done_reg, done_next;
    logic                     found_reg, found_next;

    logic [RCW-1:0]    m_cnt;
    logic [CCW-1:0]    n_cnt;
    logic [IW-1:0]     mid_calc;
    logic [IW-1:0]     mid_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] mid_row_addr;
    logic              wr_en;
    logic              accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign found  = found_reg;

    // Clamp counts to the store size
    assign m_cnt = (32'(row_count_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(row_count_reg);
    assign n_cnt = (32'(col_count_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(col_count_reg);

    assign mid_calc     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_inc      = mid_reg + IW'(1);
    assign mid_row_addr = ADDR_W'(mid_reg) * ADDR_W'(MAX_COLS);

    assign wr_addr = ADDR_W'(row_index) * ADDR_W'(MAX_COLS) + ADDR_W'(col_index);
    assign wr_en   = accept && (mode == MODE_LOAD)
                     && (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            matrix_store[wr_addr] <= entry_value;
        end
        rdata_reg <= matrix_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(16);
            col_count_reg <= CNT_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        base_reg   <= base_next;
        target_reg <= target_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        base_next   = base_reg;
        target_next = target_reg;
        done_next   = 1'b0;
        found_next  = 1'b0;
        rd_addr     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_QUERY))
                begin
                    target_next = target;
                    if ((m_cnt == '0) || (n_cnt == '0))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = IW'(m_cnt);
                        state_next = ST_ROW_PROBE;
                    end
                end
            end

            ST_ROW_PROBE:
            begin
                mid_next   = mid_calc;
                rd_addr    = ADDR_W'(mid_calc) * ADDR_W'(MAX_COLS);
                state_next = ST_ROW_FIRST;
            end

            ST_ROW_FIRST:
            begin
                if (target_reg < rdata_reg)
                begin
                    hi_next = mid_reg;
                    if (mid_reg > lo_reg)
                    begin
                        state_next = ST_ROW_PROBE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // fetch the last word of the probed row
                    rd_addr    = mid_row_addr + ADDR_W'(n_cnt) - ADDR_W'(1);
                    state_next = ST_ROW_LAST;
                end
            end

            ST_ROW_LAST:
            begin
                if (target_reg > rdata_reg)
                begin
                    lo_next = mid_inc;
                    if (mid_inc < hi_reg)
                    begin
                        state_next = ST_ROW_PROBE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // row brackets the target: search its columns from zero
                    base_next  = mid_row_addr;
                    lo_next    = '0;
                    hi_next    = IW'(n_cnt);
                    state_next = ST_COL_PROBE;
                end
            end

            ST_COL_PROBE:
            begin
                mid_next   = mid_calc;
                rd_addr    = base_reg + ADDR_W'(mid_calc);
                state_next = ST_COL_CMP;
            end

            ST_COL_CMP:
            begin
                if (target_reg < rdata_reg)
                begin
                    hi_next = mid_reg;
                    if (mid_reg > lo_reg)
                    begin
                        state_next = ST_COL_PROBE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (target_reg > rdata_reg)
                begin
                    lo_next = mid_inc;
                    if (mid_inc < hi_reg)
                    begin
                        state_next = ST_COL_PROBE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/smbs_checker.sv
// Port-level checks for the sorted matrix search unit, bound to the top level.
`timescale 1ns / 1ps

module smbs_checker
    import smbs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic done,
    input logic found
);

    // a result word comes only once the search is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    // found is meaningful only with the strobe
    a_found_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> done)
        else $error("found high without done");

    // a load word produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_LOAD)) |=> !done)
        else $error("result word after load");

    // a query either starts searching or answers at once
    a_query_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_QUERY)) |=> (busy || done))
        else $error("query word dropped");

endmodule

bind sorted_matrix_binary_search_unit smbs_checker u_smbs_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .done  (done),
    .found (found)
);

>>> verif/sorted_matrix_binary_search_unit_checker.sv
// Checker that predicts and compares the search answers of the sorted matrix search unit.
`timescale 1ns / 1ps

module sorted_matrix_binary_search_unit_checker
    import smbs_pkg::*;
#(
    parameter int ROWS_MAX = 16,
    parameter int COLS_MAX = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     mode,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] target,
    input  logic                     done,
    input  logic                     found,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CNT_W-1:0]         cfg_data,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic                     hit;
    } answer_t;

    logic signed [DATA_W-1:0] grid [ROWS_MAX][COLS_MAX];
    logic [CNT_W-1:0]         row_cnt;
    logic [CNT_W-1:0]         col_cnt;
    answer_t                  expected_answers [$];

    // Row search by first/last entry, then column search in the bracketing row.
    function automatic logic search_grid(input logic signed [DATA_W-1:0] key);
        int rows;
        int cols;
        int lo;
        int hi;
        int mid;
        int hit_row;
        rows = (row_cnt > ROWS_MAX) ? ROWS_MAX : int'(row_cnt);
        cols = (col_cnt > COLS_MAX) ? COLS_MAX : int'(col_cnt);
        if (rows == 0 || cols == 0)
            return 1'b0;
        lo = 0;
        hi = rows;
        hit_row = -1;
        while (lo < hi && hit_row < 0)
        begin
            mid = lo + (hi - lo) / 2;
            if (key < grid[mid][0])
                hi = mid;
            else if (key > grid[mid][cols-1])
                lo = mid + 1;
            else
                hit_row = mid;
        end
        if (hit_row < 0)
            return 1'b0;
        lo = 0;
        hi = cols;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key < grid[hit_row][mid])
                hi = mid;
            else if (key > grid[hit_row][mid])
                lo = mid + 1;
            else
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t head;
        answer_t fresh;
        if (!rst_n)
        begin
            row_cnt    <= CNT_W'(16);
            col_cnt    <= CNT_W'(16);
            fail_count <= 0;
            pending    <= 0;
            expected_answers.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    row_cnt <= cfg_data;
                else
                    col_cnt <= cfg_data;
            end
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: result word with no query outstanding, expected none, actual found=%0b",
                             $time, found);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    head = expected_answers.pop_front();
                    if (found !== head.hit)
                    begin
                        $display("%0t: target %0d, expected found=%0b, actual found=%0b",
                                 $time, head.key, head.hit, found);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                if (mode == MODE_LOAD)
                    grid[row_index][col_index] <= entry_value;
                else
                begin
                    fresh.key = target;
                    fresh.hit = search_grid(target);
                    expected_answers.push_back(fresh);
                end
            end
            pending <= expected_answers.size();
        end
    end

endmodule

>>> verif/sorted_matrix_binary_search_unit_test.sv
// Stimulus, watchdog and verdict for the sorted matrix search unit.
`timescale 1ns / 1ps

module sorted_matrix_binary_search_unit_test;
    import smbs_pkg::*;

    localparam int ROWS_MAX    = 16;
    localparam int COLS_MAX    = 16;
    localparam int ITEM_TARGET = 1300;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    logic                     mode        = MODE_LOAD;
    logic [IDX_W-1:0]         row_index   = '0;
    logic [IDX_W-1:0]         col_index   = '0;
    logic signed [DATA_W-1:0] entry_value = '0;
    logic signed [DATA_W-1:0] target      = '0;
    logic                     done;
    logic                     found;
    logic                     cfg_we      = 1'b0;
    logic                     cfg_index   = REG_ROW_COUNT;
    logic [CNT_W-1:0]         cfg_data    = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int items_sent  = 0;
    int rows_used   = ROWS_MAX;
    int cols_used   = COLS_MAX;
    int noise_pct;
    bit steady      = 1'b0;

    // Stimulus-side copy of what was loaded, used to pick targets.
    logic signed [DATA_W-1:0] shadow [ROWS_MAX][COLS_MAX];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_matrix_binary_search_unit #(
        .MAX_ROWS (ROWS_MAX),
        .MAX_COLS (COLS_MAX)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .target      (target),
        .done        (done),
        .found       (found),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    sorted_matrix_binary_search_unit_checker #(
        .ROWS_MAX (ROWS_MAX),
        .COLS_MAX (COLS_MAX)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .target      (target),
        .done        (done),
        .found       (found),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Stall watchdog: any accepted word, result word or register write resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("sorted_matrix_binary_search_unit verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic m, input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                             input logic signed [DATA_W-1:0] ev,
                             input logic signed [DATA_W-1:0] tg);
        // outside the steady phase, idle each cycle with a 30 percent chance
        while (!steady && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= m;
        row_index   <= r;
        col_index   <= c;
        entry_value <= ev;
        target      <= tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m == MODE_LOAD)
            shadow[r][c] = ev;
        items_sent++;
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                              input logic signed [DATA_W-1:0] v);
        send_item(MODE_LOAD, r, c, v, DATA_W'($urandom));
    endtask

    task automatic query(input logic signed [DATA_W-1:0] t);
        send_item(MODE_QUERY, IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom), t);
    endtask

    // Drop start and let every outstanding word and any load in flight finish.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_counts(input logic [CNT_W-1:0] rows_val, input logic [CNT_W-1:0] cols_val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= rows_val;
        @(posedge clk);
        cfg_index <= REG_COL_COUNT;
        cfg_data  <= cols_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_used = (rows_val > ROWS_MAX) ? ROWS_MAX : int'(rows_val);
        cols_used = (cols_val > COLS_MAX) ? COLS_MAX : int'(cols_val);
    endtask

    // Load the in-use block row by row with non-decreasing values.
    task automatic fill_sorted(input bit wide);
        longint v;
        longint step_cap;
        int     cells;
        int     r;
        int     c;
        cells = rows_used * cols_used;
        if (cells == 0)
            return;
        if (wide)
        begin
            v        = -64'sd2147483648 + $urandom_range(0, 1000);
            step_cap = (64'sd4294967295 - 2048) / cells;
        end
        else
        begin
            v = longint'(int'($urandom)) / 2;
            case ($urandom_range(2))
                0:       step_cap = 1;
                1:       step_cap = 4;
                default: step_cap = 60;
            endcase
        end
        for (r = 0; r < rows_used; r++)
            for (c = 0; c < cols_used; c++)
            begin
                load_entry(IDX_W'(r), IDX_W'(c), DATA_W'(v));
                v += $urandom_range(0, 32'(step_cap));
            end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_target();
        logic signed [DATA_W-1:0] pick;
        int roll;
        roll = $urandom_range(99);
        if (rows_used == 0 || cols_used == 0 || roll >= 85)
        begin
            case ($urandom_range(3))
                0:       pick = MIN_VAL;
                1:       pick = MAX_VAL;
                default: pick = DATA_W'($urandom);
            endcase
        end
        else
        begin
            pick = shadow[$urandom_range(rows_used - 1)][$urandom_range(cols_used - 1)];
            // Step just off a stored value to land in row gaps and between rows.
            if (roll >= 50)
                pick = $urandom_range(1) ? pick + 1 : pick - 1;
        end
        return pick;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 10)
            return CNT_W'($urandom_range(17, 31));
        if (roll < 30)
            return CNT_W'(16);
        if (roll < 42)
            return CNT_W'(1);
        return CNT_W'($urandom_range(2, 8));
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write every entry once so no search ever reads an unwritten word.
        fill_sorted(1'b1);
        load_entry(IDX_W'(0), IDX_W'(0), MIN_VAL);
        load_entry(IDX_W'(ROWS_MAX - 1), IDX_W'(COLS_MAX - 1), MAX_VAL);
        query(MIN_VAL);
        query(MAX_VAL);
        query(shadow[7][3]);
        query(shadow[7][3] + 1);
        query(shadow[7][COLS_MAX-1] + 1);
        query(shadow[8][0] - 1);
        query('0);
        query(-1);
        set_counts(CNT_W'(1), CNT_W'(1));
        query(MIN_VAL);
        query(MAX_VAL);
        set_counts(CNT_W'(0), CNT_W'(16));
        query(MIN_VAL);
        set_counts(CNT_W'(16), CNT_W'(0));
        query(MIN_VAL);
        set_counts(CNT_W'(31), CNT_W'(31));
        query(MAX_VAL);
        query(shadow[15][14]);
        set_counts(CNT_W'(5), CNT_W'(16));
        query(shadow[4][15]);
        query(shadow[5][0]);

        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 500 && items_sent < 800);
            set_counts(pick_count(), pick_count());
            noise_pct = ($urandom_range(3) == 0) ? 15 : 0;
            fill_sorted($urandom_range(3) == 0);
            repeat ($urandom_range(20, 40))
            begin
                if ($urandom_range(99) < noise_pct)
                    load_entry(IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
                else
                    query(pick_target());
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("sorted_matrix_binary_search_unit verification clean");
        else
            $display("sorted_matrix_binary_search_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/smbs_pkg.sv
src/sorted_matrix_binary_search_unit.sv
src/smbs_checker.sv
verif/sorted_matrix_binary_search_unit_checker.sv
verif/sorted_matrix_binary_search_unit_test.sv
